### rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, codes and interface types of the bounded deque block.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH      = 16;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int ACT_W      = 2;
  localparam int END_W      = 2;
  localparam int TAG_W      = 2;
  localparam int VAL_W      = 32;
  localparam int STAT_W     = 3;
  localparam int NUM_W      = 5;
  localparam int ENTRY_W    = TAG_W + VAL_W;

  localparam int CAP_W      = 5;
  localparam int CMP_W      = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CAP_W-1:0]     CAP_RESET   = 5'd16;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP     = 2'd1;
  localparam logic [END_W-1:0]     END_FRONT   = 2'd0;
  localparam logic [END_W-1:0]     END_REAR    = 2'd1;
  localparam logic [TAG_W-1:0]     TAG_UNKNOWN = 2'd3;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT   = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_TRAVERSE = 2'd2,
    ACT_NOP      = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_BADEND    = 3'd3,
    ST_INTERNAL  = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic decide;
    logic trav;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic trav_go;
    logic trav_done;
  } dp_sts_t;

endpackage

### rtl/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Controller: sequences accept, decision and traversal of one command.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output bdq_pkg::ctrl_cmd_t cmd,
  input  bdq_pkg::dp_sts_t   sts
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DECIDE = 3'b010,
    S_TRAV   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.trav_go ? S_TRAV : S_IDLE;
      end
      S_TRAV: begin
        cmd.trav = 1'b1;
        if (sts.trav_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### rtl/bdq_dp.sv
// ----------------------------------------------------------------------------
// bdq_dp
// Datapath: configuration, ring pointers, entry store and result register.
// ----------------------------------------------------------------------------
module bdq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bdq_pkg::ctrl_cmd_t                  cmd,
  output bdq_pkg::dp_sts_t                    sts,
  input  logic [bdq_pkg::ACT_W-1:0]           in_action,
  input  logic [bdq_pkg::END_W-1:0]           in_end_select,
  input  logic [bdq_pkg::TAG_W-1:0]           in_entry_tag,
  input  logic [bdq_pkg::VAL_W-1:0]           in_entry_value,
  input  logic                                cfg_we,
  input  logic [bdq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bdq_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_valid,
  output logic [bdq_pkg::STAT_W-1:0]          out_status,
  output logic [bdq_pkg::TAG_W-1:0]           out_tag,
  output logic [bdq_pkg::VAL_W-1:0]           out_value,
  output logic [bdq_pkg::NUM_W-1:0]           out_entry_number,
  output logic                                out_last
);

  localparam int IDX_W = bdq_pkg::IDX_W;
  localparam int CNT_W = bdq_pkg::CNT_W;
  localparam int CMP_W = bdq_pkg::CMP_W;

  // Ring slot of a position counted from the head.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [IDX_W-1:0] pos);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (IDX_W+1)'(bdq_pkg::DEPTH)) begin
      sum = sum - (IDX_W+1)'(bdq_pkg::DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Latched command.
  bdq_pkg::action_t              act_r;
  logic [bdq_pkg::END_W-1:0]     endsel_r;
  logic [bdq_pkg::TAG_W-1:0]     tag_r;
  logic [bdq_pkg::VAL_W-1:0]     val_r;

  // Configuration and ring state.
  logic                          kind_r;
  logic [bdq_pkg::CAP_W-1:0]     cap_r;
  logic [IDX_W-1:0]              head_r, head_nxt;
  logic [CNT_W-1:0]              fill_r, fill_nxt;

  // Traversal.
  logic                          trav_rear_r;
  logic [CNT_W-1:0]              iss_r;
  logic                          rd_vld_r;
  logic [IDX_W-1:0]              rd_pos_r;
  logic                          rd_final_r;

  // Result register.
  logic                          out_valid_r;
  bdq_pkg::status_t              out_status_r;
  logic [bdq_pkg::TAG_W-1:0]     out_tag_r;
  logic [bdq_pkg::VAL_W-1:0]     out_value_r;
  logic [bdq_pkg::NUM_W-1:0]     out_num_r;
  logic                          out_last_r;

  logic [CMP_W-1:0]              cap_ext, limit;
  logic                          full, empty, bad_end, at_front;
  logic [IDX_W-1:0]              head_dec, head_inc;
  bdq_pkg::status_t              res_status;
  logic                          do_write;
  logic [IDX_W-1:0]              wr_addr;
  logic                          trav_go;
  logic                          trav_done;
  logic                          single;
  logic                          issue;
  logic [CNT_W-1:0]              iss_pos_full;
  logic [IDX_W-1:0]              iss_pos;
  logic                          iss_final;
  logic [IDX_W-1:0]              rd_addr;
  logic [bdq_pkg::ENTRY_W-1:0]   rd_data;
  logic [bdq_pkg::TAG_W-1:0]     rd_tag;
  logic                          rd_unknown;
  logic                          emit;

  assign cap_ext  = CMP_W'(cap_r);
  assign limit    = (cap_ext < CMP_W'(bdq_pkg::DEPTH)) ? cap_ext : CMP_W'(bdq_pkg::DEPTH);
  assign full     = (CMP_W'(fill_r) >= limit);
  assign empty    = (fill_r == '0);
  assign bad_end  = kind_r && !(endsel_r == bdq_pkg::END_FRONT ||
                                endsel_r == bdq_pkg::END_REAR);
  // In linear mode inserts go to the rear and everything else uses the front.
  assign at_front = kind_r ? (endsel_r == bdq_pkg::END_FRONT)
                           : (act_r != bdq_pkg::ACT_INSERT);
  assign head_dec = (head_r == '0) ? IDX_W'(bdq_pkg::DEPTH - 1) : head_r - 1'b1;
  assign head_inc = (head_r == IDX_W'(bdq_pkg::DEPTH - 1)) ? '0 : head_r + 1'b1;

  always_comb begin
    res_status  = bdq_pkg::ST_OK;
    do_write    = 1'b0;
    wr_addr     = slot_of(head_r, fill_r[IDX_W-1:0]);
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    trav_go     = 1'b0;
    case (act_r)
      bdq_pkg::ACT_INSERT: begin
        if (bad_end) begin
          res_status = bdq_pkg::ST_BADEND;
        end else if (full) begin
          res_status = bdq_pkg::ST_OVERFLOW;
        end else begin
          do_write = 1'b1;
          fill_nxt = fill_r + 1'b1;
          if (at_front) begin
            head_nxt = head_dec;
            wr_addr  = head_dec;
          end
        end
      end
      bdq_pkg::ACT_REMOVE: begin
        if (bad_end) begin
          res_status = bdq_pkg::ST_BADEND;
        end else if (empty) begin
          res_status = bdq_pkg::ST_UNDERFLOW;
        end else begin
          fill_nxt = fill_r - 1'b1;
          if (at_front) begin
            head_nxt = head_inc;
          end
        end
      end
      bdq_pkg::ACT_TRAVERSE: begin
        if (empty) begin
          res_status = bdq_pkg::ST_UNDERFLOW;
        end else if (bad_end) begin
          res_status = bdq_pkg::ST_BADEND;
        end else begin
          trav_go = 1'b1;
        end
      end
      default: begin
        res_status = bdq_pkg::ST_OK;
      end
    endcase
  end

  assign single = cmd.decide && !trav_go;

  // Traversal reads are issued one per cycle; data returns in the following cycle.
  assign rd_tag         = rd_data[bdq_pkg::ENTRY_W-1 -: bdq_pkg::TAG_W];
  assign rd_unknown     = (rd_tag == bdq_pkg::TAG_UNKNOWN);
  assign emit           = cmd.trav && rd_vld_r;
  assign trav_done      = emit && (rd_final_r || rd_unknown);
  assign issue          = cmd.trav && (iss_r < fill_r) && !trav_done;
  assign iss_pos_full   = trav_rear_r ? (fill_r - 1'b1 - iss_r) : iss_r;
  assign iss_pos        = iss_pos_full[IDX_W-1:0];
  assign iss_final      = ((iss_r + CNT_W'(1)) == fill_r);
  assign rd_addr        = slot_of(head_r, iss_pos);

  assign sts = '{trav_go: trav_go, trav_done: trav_done};

  bdq_ram #(
    .WIDTH (bdq_pkg::ENTRY_W),
    .DEPTH (bdq_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.decide && do_write),
    .waddr (wr_addr),
    .wdata ({tag_r, val_r}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r    <= bdq_pkg::action_t'(in_action);
      endsel_r <= in_end_select;
      tag_r    <= in_entry_tag;
      val_r    <= in_entry_value;
    end
    if (cmd.decide) begin
      trav_rear_r <= !at_front;
    end
    rd_pos_r   <= iss_pos;
    rd_final_r <= iss_final;
    if (single) begin
      out_status_r <= res_status;
      out_tag_r    <= '0;
      out_value_r  <= '0;
      out_num_r    <= '0;
      out_last_r   <= 1'b1;
    end else if (emit) begin
      out_status_r <= rd_unknown ? bdq_pkg::ST_INTERNAL : bdq_pkg::ST_OK;
      out_tag_r    <= rd_tag;
      out_value_r  <= rd_data[bdq_pkg::VAL_W-1:0];
      out_num_r    <= bdq_pkg::NUM_W'(rd_pos_r) + bdq_pkg::NUM_W'(1);
      out_last_r   <= rd_final_r || rd_unknown;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= 1'b0;
      cap_r       <= bdq_pkg::CAP_RESET;
      head_r      <= '0;
      fill_r      <= '0;
      iss_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == bdq_pkg::CFG_KIND) begin
        kind_r <= cfg_data[0];
      end
      if (cfg_we && cfg_index == bdq_pkg::CFG_CAP) begin
        cap_r <= cfg_data[bdq_pkg::CAP_W-1:0];
      end
      if (cmd.decide) begin
        head_r <= head_nxt;
        fill_r <= fill_nxt;
        iss_r  <= '0;
      end else if (issue) begin
        iss_r <= iss_r + 1'b1;
      end
      rd_vld_r    <= issue;
      out_valid_r <= single || emit;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_tag          = out_tag_r;
  assign out_value        = out_value_r;
  assign out_entry_number = out_num_r;
  assign out_last         = out_last_r;

endmodule

### rtl/bounded_deque_with_status.sv
// Insert, remove, ignored actions and rejected traversals: one result, strobed
// once it is registered after the decision state; the next command is taken at
// the edge that transfers that result.
// Traversal of n entries: one result per cycle after the first entry read, set
// by the single read port of the entry store.
// Reset (synchronous, rst_n low) empties the ring, restores linear mode and 16.
// ----------------------------------------------------------------------------
// bounded_deque_with_status
// Bounded queue or deque of tagged 32-bit entries held in a ring, with status.
// ----------------------------------------------------------------------------
module bounded_deque_with_status (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [bdq_pkg::ACT_W-1:0]      in_action,
  input  logic [bdq_pkg::END_W-1:0]      in_end_select,
  input  logic [bdq_pkg::TAG_W-1:0]      in_entry_tag,
  input  logic [bdq_pkg::VAL_W-1:0]      in_entry_value,
  input  logic                           cfg_we,
  input  logic [bdq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdq_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  output logic [bdq_pkg::STAT_W-1:0]     out_status,
  output logic [bdq_pkg::TAG_W-1:0]      out_tag,
  output logic [bdq_pkg::VAL_W-1:0]      out_value,
  output logic [bdq_pkg::NUM_W-1:0]      out_entry_number,
  output logic                           out_last
);

  bdq_pkg::ctrl_cmd_t cmd;
  bdq_pkg::dp_sts_t   sts;

  bdq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  bdq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_end_select    (in_end_select),
    .in_entry_tag     (in_entry_tag),
    .in_entry_value   (in_entry_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_tag          (out_tag),
    .out_value        (out_value),
    .out_entry_number (out_entry_number),
    .out_last         (out_last)
  );

endmodule

### rtl/bdq_chk.sv
// ----------------------------------------------------------------------------
// bdq_chk
// Port-level checks on command and result sequencing of the deque block.
// ----------------------------------------------------------------------------
module bdq_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [bdq_pkg::STAT_W-1:0] out_status,
  input logic                       out_last
);

  // An accepted command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted command");

  // Traversal results arrive in consecutive cycles until the final one.
  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a traversal result stream");

  // The final result of a command is never directly followed by another result.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result right after the final result of a command");

  // Any status other than ok ends the command.
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bdq_pkg::ST_OK) |-> out_last)
    else $error("error status on a result that is not the last");

  // More results pending means the block is still working on the command.
  a_pending_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("block idle while traversal results are pending");

endmodule

bind bounded_deque_with_status bdq_chk u_bdq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_last   (out_last)
);
